### design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants for the ray-triangle tester: transfer layout and formats.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

    localparam int T_FRAC   = 16;

    localparam int VEC_W    = 48;
    localparam int SCAL_W   = 32;
    localparam int NORM_W   = 16;

    localparam int IN_W     = 448;
    localparam int OUT_W    = 80;
    localparam int USER_W   = 1;

    localparam int ORG_LSB  = 0;
    localparam int DIR_LSB  = 48;
    localparam int TMIN_LSB = 96;
    localparam int TMAX_LSB = 128;
    localparam int VA_LSB   = 160;
    localparam int VB_LSB   = 208;
    localparam int VC_LSB   = 256;
    localparam int NA_LSB   = 304;
    localparam int NB_LSB   = 352;
    localparam int NC_LSB   = 400;

    localparam int HT_LSB   = 0;
    localparam int NX_LSB   = 32;
    localparam int NY_LSB   = 48;
    localparam int NZ_LSB   = 64;

endpackage

`default_nettype wire

### design/ray_triangle_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Pipelined Moller-Trumbore ray-triangle test with normal interpolation.
// Input passes stages a to g, the one-bit-per-stage quotient pipelines and a
// registered result stage.
// Throughput: one transfer per cycle; the whole pipe holds while a result waits.
// Reset: aresetn clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect_top #(
    parameter int COORD_BITS = 16,
    parameter int T_BITS     = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // ray_origin, ray_direction, t_min, t_max, vertex_a, vertex_b, vertex_c,
    // normal_a, normal_b, normal_c
    input  wire logic [rti_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // hit_t, hit_normal_x, hit_normal_y, hit_normal_z
    output logic [rti_pkg::OUT_W-1:0]        m_axis_tdata,
    // hit
    output logic [rti_pkg::USER_W-1:0]       m_axis_tuser
);

    import rti_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int T    = T_BITS;
    localparam int VW   = 3 * C;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int DPW  = CW + DW;
    localparam int SW   = DPW + 2;
    localparam int H    = SW / 2;
    localparam int UH   = SW - H;
    localparam int PLW  = H + 1 + DW;
    localparam int PHW  = UH + DW;
    localparam int XW   = SW + DW + 1;
    localparam int NUMW = SW + T_FRAC;
    localparam int TDW  = SW + T + 1;
    localparam int K    = (T > C + 1) ? T : C + 1;
    localparam int NXW  = C + 3;
    localparam int SBW  = 2 * T + 3 * C + 6 * DW;
    localparam int SNA  = 2 * T;
    localparam int SNB  = 2 * T + 3 * C;
    localparam int SNC  = 2 * T + 3 * C + 3 * DW;

    typedef logic signed [C-1:0]   crd_t;
    typedef logic signed [DW-1:0]  dif_t;
    typedef logic signed [PW-1:0]  prd_t;
    typedef logic signed [CW-1:0]  crs_t;
    typedef logic signed [DPW-1:0] dpr_t;
    typedef logic signed [SW-1:0]  sum_t;
    typedef logic signed [T-1:0]   tv_t;

    localparam logic [T:0]           T_NEG_LIM = (T+1)'(1) << (T - 1);
    localparam logic signed [NXW-1:0] N_MAX    = NXW'((2 ** (C - 1)) - 1);
    localparam logic signed [NXW-1:0] N_MIN    = -NXW'(2 ** (C - 1));

    logic en;

    // input unpack
    logic [VW-1:0] org_w, dir_w, va_w, vb_w, vc_w, na_w, nb_w, nc_w;
    crd_t org [3], dir [3], va [3], vb [3], vc [3], na [3], nb [3], nc [3];
    tv_t  tmin_in, tmax_in;

    // stage a
    logic           a_valid_reg;
    dif_t           a_dir_next [3], a_e1_next [3], a_e2_next [3], a_sv_next [3];
    dif_t           a_dir_reg [3], a_e1_reg [3], a_e2_reg [3], a_sv_reg [3];
    logic [SBW-1:0] a_side_next, a_side_reg;

    // stage b
    logic           b_valid_reg;
    prd_t           b_p1_next [6], b_p2_next [6];
    prd_t           b_p1_reg [6], b_p2_reg [6];
    dif_t           b_dir_reg [3], b_e1_reg [3], b_e2_reg [3], b_sv_reg [3];
    logic [SBW-1:0] b_side_reg;

    // stage c
    logic           c_valid_reg;
    crs_t           c_c1_next [3], c_c2_next [3];
    crs_t           c_c1_reg [3], c_c2_reg [3];
    dif_t           c_dir_reg [3], c_e1_reg [3], c_e2_reg [3], c_sv_reg [3];
    logic [SBW-1:0] c_side_reg;

    // stage d
    logic           d_valid_reg;
    dpr_t           d_det_next [3], d_u_next [3], d_tn_next [3], d_v_next [3];
    dpr_t           d_det_reg [3], d_u_reg [3], d_tn_reg [3], d_v_reg [3];
    logic [SBW-1:0] d_side_reg;

    // stage e
    logic           e_valid_reg;
    sum_t           e_det_next, e_u_next, e_tn_next, e_v_next;
    sum_t           e_det_reg, e_u_reg, e_tn_reg, e_v_reg;
    logic [SBW-1:0] e_side_reg;

    // stage f
    logic           f_valid_reg;
    logic           det_neg;
    sum_t           det_n, u_n, v_n;
    logic [SW-1:0]  f_det_next, f_tmag_next;
    sum_t           f_u_next, f_v_next;
    logic           f_tneg_next, f_ok_next;
    logic [SW-1:0]  f_det_reg, f_tmag_reg;
    sum_t           f_u_reg, f_v_reg;
    logic           f_tneg_reg, f_ok_reg;
    logic [SBW-1:0] f_side_reg;

    // stage g
    logic                  g_valid_reg;
    dif_t                  g_dnb [3], g_dnc [3];
    logic signed [PLW-1:0] g_plu_next [3], g_plv_next [3];
    logic signed [PHW-1:0] g_phu_next [3], g_phv_next [3];
    logic signed [PLW-1:0] g_plu_reg [3], g_plv_reg [3];
    logic signed [PHW-1:0] g_phu_reg [3], g_phv_reg [3];
    logic [NUMW-1:0]       g_tnum_next, g_tnum_reg;
    logic                  g_ovf_next, g_ovf_reg;
    logic [SW-1:0]         g_det_reg;
    logic                  g_tneg_reg, g_ok_reg;
    logic [SBW-1:0]        g_side_reg;

    // blend numerators into the divide pipe
    logic signed [XW-1:0]  hx [3];

    // divide pipe
    logic             dv_valid_reg [0:K];
    logic             dv_ok_reg    [0:K];
    logic             dv_tneg_reg  [0:K];
    logic             dv_ovf_reg   [0:K];
    logic [SW-1:0]    dv_det_reg   [0:K];
    logic [TDW-1:0]   dv_tr_reg    [0:K];
    logic [T-1:0]     dv_tq_reg    [0:K];
    tv_t              dv_tmin_reg  [0:K];
    tv_t              dv_tmax_reg  [0:K];
    crd_t             dv_na_reg    [0:K][0:2];
    logic [XW-1:0]    dv_nr_reg    [0:K][0:2];
    logic [C:0]       dv_nq_reg    [0:K][0:2];
    logic             dv_nneg_reg  [0:K][0:2];

    // result stage
    logic                  o_tround;
    logic [T:0]            o_tmag;
    logic                  o_tsat;
    tv_t                   o_t;
    logic                  o_hit;
    logic [C+1:0]          o_qm [3];
    logic signed [NXW-1:0] o_qs [3], o_q [3], o_ns [3];
    logic [C-1:0]          o_norm [3];
    logic                  m_valid_reg, m_hit_reg;
    logic [T-1:0]          m_t_next, m_t_reg;
    logic [C-1:0]          m_norm_next [3], m_norm_reg [3];

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign org_w = VW'(s_axis_tdata[ORG_LSB +: VEC_W]);
    assign dir_w = VW'(s_axis_tdata[DIR_LSB +: VEC_W]);
    assign va_w  = VW'(s_axis_tdata[VA_LSB +: VEC_W]);
    assign vb_w  = VW'(s_axis_tdata[VB_LSB +: VEC_W]);
    assign vc_w  = VW'(s_axis_tdata[VC_LSB +: VEC_W]);
    assign na_w  = VW'(s_axis_tdata[NA_LSB +: VEC_W]);
    assign nb_w  = VW'(s_axis_tdata[NB_LSB +: VEC_W]);
    assign nc_w  = VW'(s_axis_tdata[NC_LSB +: VEC_W]);
    assign tmin_in = $signed(T'(s_axis_tdata[TMIN_LSB +: SCAL_W]));
    assign tmax_in = $signed(T'(s_axis_tdata[TMAX_LSB +: SCAL_W]));

    // stage a: unpack and edge vectors
    always_comb begin
        a_side_next = '0;
        a_side_next[T-1:0]   = tmin_in;
        a_side_next[2*T-1:T] = tmax_in;
        for (int i = 0; i < 3; i++) begin
            org[i] = $signed(org_w[i*C +: C]);
            dir[i] = $signed(dir_w[i*C +: C]);
            va[i]  = $signed(va_w[i*C +: C]);
            vb[i]  = $signed(vb_w[i*C +: C]);
            vc[i]  = $signed(vc_w[i*C +: C]);
            na[i]  = $signed(na_w[i*C +: C]);
            nb[i]  = $signed(nb_w[i*C +: C]);
            nc[i]  = $signed(nc_w[i*C +: C]);
            a_dir_next[i] = DW'(dir[i]);
            a_e1_next[i]  = DW'(vb[i]) - DW'(va[i]);
            a_e2_next[i]  = DW'(vc[i]) - DW'(va[i]);
            a_sv_next[i]  = DW'(org[i]) - DW'(va[i]);
            a_side_next[SNA + i*C +: C]   = na[i];
            a_side_next[SNB + i*DW +: DW] = DW'(nb[i]) - DW'(na[i]);
            a_side_next[SNC + i*DW +: DW] = DW'(nc[i]) - DW'(na[i]);
        end
    end

    // stage b: cross product terms
    always_comb begin
        b_p1_next[0] = PW'(a_dir_reg[1]) * PW'(a_e2_reg[2]);
        b_p1_next[1] = PW'(a_dir_reg[2]) * PW'(a_e2_reg[1]);
        b_p1_next[2] = PW'(a_dir_reg[2]) * PW'(a_e2_reg[0]);
        b_p1_next[3] = PW'(a_dir_reg[0]) * PW'(a_e2_reg[2]);
        b_p1_next[4] = PW'(a_dir_reg[0]) * PW'(a_e2_reg[1]);
        b_p1_next[5] = PW'(a_dir_reg[1]) * PW'(a_e2_reg[0]);
        b_p2_next[0] = PW'(a_sv_reg[1]) * PW'(a_e1_reg[2]);
        b_p2_next[1] = PW'(a_sv_reg[2]) * PW'(a_e1_reg[1]);
        b_p2_next[2] = PW'(a_sv_reg[2]) * PW'(a_e1_reg[0]);
        b_p2_next[3] = PW'(a_sv_reg[0]) * PW'(a_e1_reg[2]);
        b_p2_next[4] = PW'(a_sv_reg[0]) * PW'(a_e1_reg[1]);
        b_p2_next[5] = PW'(a_sv_reg[1]) * PW'(a_e1_reg[0]);
    end

    // stage c: cross products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_c1_next[i] = CW'(b_p1_reg[2*i]) - CW'(b_p1_reg[2*i+1]);
            c_c2_next[i] = CW'(b_p2_reg[2*i]) - CW'(b_p2_reg[2*i+1]);
        end
    end

    // stage d: dot product terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_det_next[i] = DPW'(c_c1_reg[i]) * DPW'(c_e1_reg[i]);
            d_u_next[i]   = DPW'(c_c1_reg[i]) * DPW'(c_sv_reg[i]);
            d_tn_next[i]  = DPW'(c_c2_reg[i]) * DPW'(c_e2_reg[i]);
            d_v_next[i]   = DPW'(c_c2_reg[i]) * DPW'(c_dir_reg[i]);
        end
    end

    // stage e: triple products
    always_comb begin
        e_det_next = SW'(d_det_reg[0]) + SW'(d_det_reg[1]) + SW'(d_det_reg[2]);
        e_u_next   = SW'(d_u_reg[0]) + SW'(d_u_reg[1]) + SW'(d_u_reg[2]);
        e_tn_next  = SW'(d_tn_reg[0]) + SW'(d_tn_reg[1]) + SW'(d_tn_reg[2]);
        e_v_next   = SW'(d_v_reg[0]) + SW'(d_v_reg[1]) + SW'(d_v_reg[2]);
    end

    // stage f: make det positive, barycentric test
    always_comb begin
        det_neg     = e_det_reg[SW-1];
        det_n       = det_neg ? -e_det_reg : e_det_reg;
        u_n         = det_neg ? -e_u_reg : e_u_reg;
        v_n         = det_neg ? -e_v_reg : e_v_reg;
        f_det_next  = det_n;
        f_u_next    = u_n;
        f_v_next    = v_n;
        f_tmag_next = e_tn_reg[SW-1] ? -e_tn_reg : e_tn_reg;
        f_tneg_next = e_tn_reg[SW-1] ^ det_neg;
        f_ok_next   = (e_det_reg != '0) && !u_n[SW-1] && !v_n[SW-1]
                      && ((SW+1)'(u_n) + (SW+1)'(v_n) <= (SW+1)'(det_n));
    end

    // stage g: normal blend partial products, distance overflow check
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_dnb[i] = $signed(f_side_reg[SNB + i*DW +: DW]);
            g_dnc[i] = $signed(f_side_reg[SNC + i*DW +: DW]);
            g_plu_next[i] = PLW'($signed({1'b0, f_u_reg[H-1:0]})) * PLW'(g_dnb[i]);
            g_phu_next[i] = PHW'($signed(f_u_reg[SW-1:H])) * PHW'(g_dnb[i]);
            g_plv_next[i] = PLW'($signed({1'b0, f_v_reg[H-1:0]})) * PLW'(g_dnc[i]);
            g_phv_next[i] = PHW'($signed(f_v_reg[SW-1:H])) * PHW'(g_dnc[i]);
        end
        g_tnum_next = {f_tmag_reg, {T_FRAC{1'b0}}};
        g_ovf_next  = TDW'(g_tnum_next) >= (TDW'(f_det_reg) << T);
    end

    // blend numerator per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hx[i] = (XW'(g_phu_reg[i]) <<< H) + XW'(g_plu_reg[i])
                  + (XW'(g_phv_reg[i]) <<< H) + XW'(g_plv_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            e_valid_reg     <= 1'b0;
            f_valid_reg     <= 1'b0;
            g_valid_reg     <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            a_valid_reg     <= s_axis_tvalid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            d_valid_reg     <= c_valid_reg;
            e_valid_reg     <= d_valid_reg;
            f_valid_reg     <= e_valid_reg;
            g_valid_reg     <= f_valid_reg;
            dv_valid_reg[0] <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dir_reg  <= a_dir_next;
            a_e1_reg   <= a_e1_next;
            a_e2_reg   <= a_e2_next;
            a_sv_reg   <= a_sv_next;
            a_side_reg <= a_side_next;

            b_p1_reg   <= b_p1_next;
            b_p2_reg   <= b_p2_next;
            b_dir_reg  <= a_dir_reg;
            b_e1_reg   <= a_e1_reg;
            b_e2_reg   <= a_e2_reg;
            b_sv_reg   <= a_sv_reg;
            b_side_reg <= a_side_reg;

            c_c1_reg   <= c_c1_next;
            c_c2_reg   <= c_c2_next;
            c_dir_reg  <= b_dir_reg;
            c_e1_reg   <= b_e1_reg;
            c_e2_reg   <= b_e2_reg;
            c_sv_reg   <= b_sv_reg;
            c_side_reg <= b_side_reg;

            d_det_reg  <= d_det_next;
            d_u_reg    <= d_u_next;
            d_tn_reg   <= d_tn_next;
            d_v_reg    <= d_v_next;
            d_side_reg <= c_side_reg;

            e_det_reg  <= e_det_next;
            e_u_reg    <= e_u_next;
            e_tn_reg   <= e_tn_next;
            e_v_reg    <= e_v_next;
            e_side_reg <= d_side_reg;

            f_det_reg  <= f_det_next;
            f_u_reg    <= f_u_next;
            f_v_reg    <= f_v_next;
            f_tmag_reg <= f_tmag_next;
            f_tneg_reg <= f_tneg_next;
            f_ok_reg   <= f_ok_next;
            f_side_reg <= e_side_reg;

            g_plu_reg  <= g_plu_next;
            g_phu_reg  <= g_phu_next;
            g_plv_reg  <= g_plv_next;
            g_phv_reg  <= g_phv_next;
            g_tnum_reg <= g_tnum_next;
            g_ovf_reg  <= g_ovf_next;
            g_det_reg  <= f_det_reg;
            g_tneg_reg <= f_tneg_reg;
            g_ok_reg   <= f_ok_reg;
            g_side_reg <= f_side_reg;

            dv_ok_reg[0]   <= g_ok_reg;
            dv_tneg_reg[0] <= g_tneg_reg;
            dv_ovf_reg[0]  <= g_ovf_reg;
            dv_det_reg[0]  <= g_det_reg;
            dv_tr_reg[0]   <= TDW'(g_tnum_reg);
            dv_tq_reg[0]   <= '0;
            dv_tmin_reg[0] <= $signed(g_side_reg[T-1:0]);
            dv_tmax_reg[0] <= $signed(g_side_reg[2*T-1:T]);
            for (int i = 0; i < 3; i++) begin
                dv_na_reg[0][i]   <= $signed(g_side_reg[SNA + i*C +: C]);
                dv_nneg_reg[0][i] <= hx[i][XW-1];
                dv_nr_reg[0][i]   <= hx[i][XW-1] ? XW'(-hx[i]) : XW'(hx[i]);
                dv_nq_reg[0][i]   <= '0;
            end
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < K; k++) begin : g_div
        logic [TDW-1:0] tr_next;
        logic [T-1:0]   tq_next;
        logic [XW-1:0]  nr_next [3];
        logic [C:0]     nq_next [3];

        if (k < T) begin : g_tstep
            localparam int TB = T - 1 - k;
            logic [TDW-1:0] t_sub;
            logic           t_take;
            assign t_sub   = TDW'(dv_det_reg[k]) << TB;
            assign t_take  = dv_tr_reg[k] >= t_sub;
            assign tr_next = t_take ? dv_tr_reg[k] - t_sub : dv_tr_reg[k];
            assign tq_next = dv_tq_reg[k] | (T'(t_take) << TB);
        end else begin : g_tpass
            assign tr_next = dv_tr_reg[k];
            assign tq_next = dv_tq_reg[k];
        end

        for (genvar j = 0; j < 3; j++) begin : g_axis
            if (k <= C) begin : g_nstep
                localparam int NB = C - k;
                logic [XW-1:0] n_sub;
                logic          n_take;
                assign n_sub      = XW'(dv_det_reg[k]) << NB;
                assign n_take     = dv_nr_reg[k][j] >= n_sub;
                assign nr_next[j] = n_take ? dv_nr_reg[k][j] - n_sub : dv_nr_reg[k][j];
                assign nq_next[j] = dv_nq_reg[k][j] | ((C+1)'(n_take) << NB);
            end else begin : g_npass
                assign nr_next[j] = dv_nr_reg[k][j];
                assign nq_next[j] = dv_nq_reg[k][j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_ok_reg[k+1]   <= dv_ok_reg[k];
                dv_tneg_reg[k+1] <= dv_tneg_reg[k];
                dv_ovf_reg[k+1]  <= dv_ovf_reg[k];
                dv_det_reg[k+1]  <= dv_det_reg[k];
                dv_tr_reg[k+1]   <= tr_next;
                dv_tq_reg[k+1]   <= tq_next;
                dv_tmin_reg[k+1] <= dv_tmin_reg[k];
                dv_tmax_reg[k+1] <= dv_tmax_reg[k];
                for (int i = 0; i < 3; i++) begin
                    dv_na_reg[k+1][i]   <= dv_na_reg[k][i];
                    dv_nneg_reg[k+1][i] <= dv_nneg_reg[k][i];
                    dv_nr_reg[k+1][i]   <= nr_next[i];
                    dv_nq_reg[k+1][i]   <= nq_next[i];
                end
            end
        end
    end

    // floor rounding, saturation, interval test, miss clearing
    always_comb begin
        o_tround = dv_tneg_reg[K] && (dv_tr_reg[K] != '0);
        o_tmag   = {1'b0, dv_tq_reg[K]} + (T+1)'(o_tround);
        if (dv_tneg_reg[K]) begin
            o_tsat = dv_ovf_reg[K] || (o_tmag > T_NEG_LIM);
            o_t    = o_tsat ? tv_t'({1'b1, {(T-1){1'b0}}})
                            : $signed(T'(0) - o_tmag[T-1:0]);
        end else begin
            o_tsat = dv_ovf_reg[K] || dv_tq_reg[K][T-1];
            o_t    = o_tsat ? tv_t'({1'b0, {(T-1){1'b1}}}) : $signed(dv_tq_reg[K]);
        end
        o_hit = dv_ok_reg[K] && (o_t <= dv_tmax_reg[K]) && (o_t >= dv_tmin_reg[K]);

        for (int i = 0; i < 3; i++) begin
            o_qm[i] = {1'b0, dv_nq_reg[K][i]}
                    + (C+2)'(dv_nneg_reg[K][i] && (dv_nr_reg[K][i] != '0));
            o_qs[i] = $signed({1'b0, o_qm[i]});
            o_q[i]  = dv_nneg_reg[K][i] ? -o_qs[i] : o_qs[i];
            o_ns[i] = NXW'(dv_na_reg[K][i]) + o_q[i];
            if (o_ns[i] > N_MAX) begin
                o_norm[i] = N_MAX[C-1:0];
            end else if (o_ns[i] < N_MIN) begin
                o_norm[i] = N_MIN[C-1:0];
            end else begin
                o_norm[i] = o_ns[i][C-1:0];
            end
            m_norm_next[i] = o_hit ? o_norm[i] : '0;
        end
        m_t_next = o_hit ? o_t : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid_reg[K];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg  <= o_hit;
            m_t_reg    <= m_t_next;
            m_norm_reg <= m_norm_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = USER_W'(m_hit_reg);
    assign m_axis_tdata  = {NORM_W'(m_norm_reg[2]), NORM_W'(m_norm_reg[1]),
                            NORM_W'(m_norm_reg[0]), SCAL_W'(m_t_reg)};

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_triangle_intersect_top. Random and directed
// ray/triangle transfers are scored against an exact wide-integer model of the
// Moller-Trumbore test, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

typedef logic signed [127:0] wide_t;
typedef wide_t vec_t [3];

typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
} isect_t;

class isect_scoreboard;
    isect_t pending[$];
    int     errors;
    int     hits;
    int     misses;

    static function vec_t unpack3(logic [47:0] p);
        vec_t v;
        for (int i = 0; i < 3; i++) v[i] = $signed(p[i*16 +: 16]);
        return v;
    endfunction

    static function vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
        return r;
    endfunction

    static function vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    static function wide_t vdot(vec_t a, vec_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    static function wide_t div_floor(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n % d != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    static function wide_t clamp(wide_t v, int bits);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    static function isect_t predict(logic [rti_pkg::IN_W-1:0] d);
        vec_t  org, dir, pa, pb, pc, e1, e2, sv, c1, c2;
        vec_t  nrm [3];
        wide_t det, tn, u, v, w0, tq, tlo, thi, s;
        wide_t nout [3];
        isect_t r;
        r   = '0;
        org = unpack3(d[rti_pkg::ORG_LSB +: 48]);
        dir = unpack3(d[rti_pkg::DIR_LSB +: 48]);
        tlo = $signed(d[rti_pkg::TMIN_LSB +: 32]);
        thi = $signed(d[rti_pkg::TMAX_LSB +: 32]);
        pa  = unpack3(d[rti_pkg::VA_LSB +: 48]);
        pb  = unpack3(d[rti_pkg::VB_LSB +: 48]);
        pc  = unpack3(d[rti_pkg::VC_LSB +: 48]);
        nrm[0] = unpack3(d[rti_pkg::NA_LSB +: 48]);
        nrm[1] = unpack3(d[rti_pkg::NB_LSB +: 48]);
        nrm[2] = unpack3(d[rti_pkg::NC_LSB +: 48]);
        e1  = vsub(pb, pa);
        e2  = vsub(pc, pa);
        sv  = vsub(org, pa);
        c1  = vcross(dir, e2);
        c2  = vcross(sv, e1);
        det = vdot(c1, e1);
        tn  = vdot(c2, e2);
        u   = vdot(c1, sv);
        v   = vdot(c2, dir);
        if (det == 0) return r;
        if (det < 0) begin
            det = -det;
            tn  = -tn;
            u   = -u;
            v   = -v;
        end
        tq = clamp(div_floor(tn <<< 16, det), 32);
        if (tq > thi || tq < tlo) return r;
        if (u < 0 || v < 0) return r;
        w0 = det - (u + v);
        if (w0 < 0) return r;
        for (int i = 0; i < 3; i++) begin
            s = w0 * nrm[0][i] + u * nrm[1][i] + v * nrm[2][i];
            nout[i] = clamp(div_floor(s, det), 16);
        end
        r.hit = 1'b1;
        r.t   = tq[31:0];
        r.nx  = nout[0][15:0];
        r.ny  = nout[1][15:0];
        r.nz  = nout[2][15:0];
        return r;
    endfunction

    function void note_ray(logic [rti_pkg::IN_W-1:0] d);
        pending.push_back(predict(d));
    endfunction

    function void check_result(logic [rti_pkg::OUT_W-1:0] d, logic hit);
        isect_t e;
        if (pending.size() == 0) begin
            $error("result with no pending ray");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.hit) hits++; else misses++;
        if (hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit);
            errors++;
        end
        if (d[rti_pkg::HT_LSB +: 32] !== e.t) begin
            $error("hit_t: expected %h actual %h", e.t, d[rti_pkg::HT_LSB +: 32]);
            errors++;
        end
        if (d[rti_pkg::NX_LSB +: 16] !== e.nx) begin
            $error("hit_normal_x: expected %h actual %h", e.nx, d[rti_pkg::NX_LSB +: 16]);
            errors++;
        end
        if (d[rti_pkg::NY_LSB +: 16] !== e.ny) begin
            $error("hit_normal_y: expected %h actual %h", e.ny, d[rti_pkg::NY_LSB +: 16]);
            errors++;
        end
        if (d[rti_pkg::NZ_LSB +: 16] !== e.nz) begin
            $error("hit_normal_z: expected %h actual %h", e.nz, d[rti_pkg::NZ_LSB +: 16]);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [rti_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [rti_pkg::OUT_W-1:0] m_axis_tdata;
    logic [rti_pkg::USER_W-1:0] m_axis_tuser;

    logic                      no_idle;
    isect_scoreboard           sb;

    ray_triangle_intersect_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_ray(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    function automatic logic [47:0] pack3(int x, int y, int z);
        logic [15:0] a, b, c;
        a = 16'(x);
        b = 16'(y);
        c = 16'(z);
        return {c, b, a};
    endfunction

    function automatic int srand(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic logic [rti_pkg::IN_W-1:0] build(
        logic [47:0] org, logic [47:0] dir, logic [31:0] tmin, logic [31:0] tmax,
        logic [47:0] va, logic [47:0] vb, logic [47:0] vc,
        logic [47:0] na, logic [47:0] nb, logic [47:0] nc);
        return {nc, nb, na, vc, vb, va, tmax, tmin, dir, org};
    endfunction

    task automatic send_ray(logic [rti_pkg::IN_W-1:0] d);
        while (!no_idle && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    function automatic logic [rti_pkg::IN_W-1:0] aimed_ray();
        int ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz, px, py, pz;
        logic [31:0] tmin, tmax;
        ax = srand(4096); ay = srand(4096); az = srand(4096);
        bx = srand(4096); by = srand(4096); bz = srand(4096);
        cx = srand(4096); cy = srand(4096); cz = srand(4096);
        ox = srand(4096); oy = srand(4096); oz = srand(4096);
        px = (ax + bx + cx) / 3 + srand(600);
        py = (ay + by + cy) / 3 + srand(600);
        pz = (az + bz + cz) / 3 + srand(600);
        case ($urandom_range(3))
            0: begin tmin = 0; tmax = 32'h7fffffff; end
            1: begin tmin = $urandom_range(32'h10000); tmax = $urandom_range(32'h20000); end
            2: begin tmin = $urandom; tmax = $urandom; end
            default: begin tmin = 32'h80000000; tmax = 32'h10000; end
        endcase
        return build(pack3(ox, oy, oz), pack3(px - ox, py - oy, pz - oz), tmin, tmax,
                     pack3(ax, ay, az), pack3(bx, by, bz), pack3(cx, cy, cz),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}));
    endfunction

    function automatic logic [rti_pkg::IN_W-1:0] noise_ray();
        logic [rti_pkg::IN_W-1:0] d;
        for (int i = 0; i < rti_pkg::IN_W / 32; i++) d[i*32 +: 32] = $urandom;
        return d;
    endfunction

    initial begin
        logic [47:0] n_up, n_pos, n_neg, tri_a, tri_b, tri_c, org0, dir0;
        sb = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        no_idle       = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit triangle in z = 0 plane, ray from z = -1 down the z axis
        tri_a = pack3(0, 0, 0);
        tri_b = pack3(256, 0, 0);
        tri_c = pack3(0, 256, 0);
        org0  = pack3(64, 64, -256);
        dir0  = pack3(0, 0, 256);
        n_up  = pack3(0, 0, 256);
        n_pos = pack3(32767, 32767, 32767);
        n_neg = pack3(-32768, -32768, -32768);
        send_ray(build(org0, dir0, 0, 32'h7fffffff, tri_a, tri_b, tri_c, n_up, n_up, n_up));
        // hit exactly at a vertex and on an edge
        send_ray(build(pack3(0, 0, -256), dir0, 0, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_pos, n_neg));
        send_ray(build(pack3(128, 128, -256), dir0, 0, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_pos, n_pos, n_neg));
        // just outside
        send_ray(build(pack3(129, 128, -256), dir0, 0, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(pack3(-1, 10, -256), dir0, 0, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_up, n_up));
        // parallel ray and degenerate triangle
        send_ray(build(org0, pack3(256, 0, 0), 0, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(org0, dir0, 0, 32'h7fffffff, tri_a, tri_a, tri_a, n_up, n_up, n_up));
        // interval edges: t exactly 1.0 at both bounds, empty interval, behind origin
        send_ray(build(org0, dir0, 32'h10000, 32'h10000, tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(org0, dir0, 32'h10001, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(org0, dir0, 0, 32'hffff, tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(org0, dir0, 32'h20000, 32'h10000, tri_a, tri_b, tri_c, n_up, n_up, n_up));
        send_ray(build(org0, pack3(0, 0, -256), 32'h80000000, 32'h7fffffff,
                       tri_a, tri_b, tri_c, n_up, n_up, n_up));
        // saturated distance passes only with the largest t_max
        send_ray(build(pack3(0, 0, -32768), pack3(0, 0, 1), 0, 32'h7fffffff,
                       pack3(-32768, -32768, 32767), pack3(32767, -32768, 32767),
                       pack3(-32768, 32767, 32767), n_pos, n_pos, n_pos));
        send_ray(build(pack3(0, 0, -32768), pack3(0, 0, 1), 0, 32'h7ffffffe,
                       pack3(-32768, -32768, 32767), pack3(32767, -32768, 32767),
                       pack3(-32768, 32767, 32767), n_neg, n_neg, n_neg));
        // extreme normals, reversed winding
        send_ray(build(org0, dir0, 0, 32'h7fffffff, tri_a, tri_c, tri_b, n_pos, n_neg, n_pos));
        send_ray(build(org0, dir0, 0, 32'h7fffffff, tri_a, tri_b, tri_c, n_neg, n_neg, n_neg));
        send_ray({rti_pkg::IN_W{1'b1}});
        send_ray('0);

        for (int i = 0; i < 850; i++) begin
            if (i == 300) no_idle = 1'b1;
            if (i == 450) no_idle = 1'b0;
            send_ray(($urandom_range(99) < 65) ? aimed_ray() : noise_ray());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("checked %0d results: %0d hits, %0d misses", sb.hits + sb.misses,
                 sb.hits, sb.misses);
        $display("directed edge, parallel, interval and saturation cases plus random rays");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
